// ----- rtl/rmh_pkg.sv -----
// Shared types, constants and the heap order function for the running median unit.
// No dependencies.
package rmh_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int DATA_W       = 32;
    localparam int MED_W        = 33;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH_BEGIN,
        OP_READ_PARENT,
        OP_PUSH_MOVE,
        OP_PLACE,
        OP_POP_BEGIN,
        OP_POP_LOADV,
        OP_READ_LEFT,
        OP_TAKE_LEFT,
        OP_TAKE_RIGHT,
        OP_SINK_STEP,
        OP_FINISH
    } op_t;

    // sel: 0 = lower half (max-heap), 1 = upper half (min-heap)
    typedef struct packed {
        op_t  op;
        logic sel;
        logic src_popped;
        logic ovf;
    } cmd_t;

    typedef struct packed {
        logic idx_zero;
        logic above_parent;
        logic left_lt_n;
        logic right_lt_n;
        logic best_is_idx;
        logic full;
        logic go_lower;
        logic need_l2u;
        logic need_u2l;
    } status_t;

    // true if a must sit above b in the selected heap
    function automatic logic above(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b,
                                   input logic sel);
        logic r;
        r = sel ? (a < b) : (a > b);
        return r;
    endfunction

endpackage

// ----- rtl/running_median_two_heaps_unit.sv -----
// Top level of the running median unit: controller plus heap datapath.
// Depends on rmh_pkg, rmh_ctrl and rmh_datapath.
//
// Each sample transfers in at a clock edge with start high and busy low. The
// unit keeps all samples in two heaps (lower half as a max-heap, upper half as
// a min-heap, lower holding equal or one more) and, once the insert and any
// rebalance are finished, drives one result with done high for exactly one
// cycle: twice the median (33-bit signed, exact), the sample count and the
// overflow flag. The receiver cannot stall, so capture the result on that
// cycle. A sample arriving with CAPACITY samples held is refused: overflow is
// set and the median and count describe the unchanged set; busy stays low and
// done is high in the cycle right after the transfer. An accepted sample is
// sifted up in its heap until it reaches the root or a parent stops it. When
// a rebalance is needed, the top of the larger heap is popped, that heap is
// sifted down and the popped value is sifted up in the receiving heap. All
// steps share a single read and a single write port per heap memory. busy
// stays high for the whole insert, and done rises in the same cycle that busy
// falls, so the next sample can transfer on that cycle. The heap memories need
// no clearing after reset.
module running_median_two_heaps_unit #(
    parameter int CAPACITY = rmh_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rmh_pkg::DATA_W-1:0] sample,
    output logic                              done,
    output logic signed [rmh_pkg::MED_W-1:0]  median_times_two,
    output logic [$clog2(CAPACITY+1)-1:0]     sample_count,
    output logic                              overflow
);

    rmh_pkg::cmd_t    cmd;
    rmh_pkg::status_t status;

    rmh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rmh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample           (sample),
        .cmd              (cmd),
        .status           (status),
        .median_times_two (median_times_two),
        .sample_count     (sample_count),
        .overflow         (overflow)
    );

    // accepted sample leads either to a busy insert or to an immediate refusal
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted sample neither started nor refused");

    // a refusal only happens with the store exactly full
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (32'(sample_count) == 32'(CAPACITY)))
        else $error("overflow reported with store not full");

    // count never exceeds capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(sample_count) <= 32'(CAPACITY)))
        else $error("sample count above capacity");

endmodule

// ----- rtl/rmh_ctrl.sv -----
// Sequencer for the running median unit: walks insert, rebalance pop and push.
// Depends on rmh_pkg.
module rmh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rmh_pkg::status_t status,
    output rmh_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHOOSE,
        S_PUSH,
        S_PCMP,
        S_CHECK,
        S_POPV,
        S_SINK,
        S_LEFT,
        S_RIGHT,
        S_DEC,
        S_XFER
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   done_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cmd.op         = rmh_pkg::OP_NONE;
        cmd.sel        = sel_reg;
        cmd.src_popped = 1'b0;
        cmd.ovf        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (status.full)
                    begin
                        cmd.op  = rmh_pkg::OP_FINISH;
                        cmd.ovf = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = rmh_pkg::OP_LOAD;
                        state_next = S_CHOOSE;
                    end
                end
            end
            S_CHOOSE:
            begin
                sel_next   = !status.go_lower;
                cmd.sel    = !status.go_lower;
                cmd.op     = rmh_pkg::OP_PUSH_BEGIN;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (status.idx_zero)
                begin
                    cmd.op     = rmh_pkg::OP_PLACE;
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.op     = rmh_pkg::OP_READ_PARENT;
                    state_next = S_PCMP;
                end
            end
            S_PCMP:
            begin
                if (status.above_parent)
                begin
                    cmd.op     = rmh_pkg::OP_PUSH_MOVE;
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.op     = rmh_pkg::OP_PLACE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.need_l2u || status.need_u2l)
                begin
                    sel_next   = status.need_u2l;
                    cmd.sel    = status.need_u2l;
                    cmd.op     = rmh_pkg::OP_POP_BEGIN;
                    state_next = S_POPV;
                end
                else
                begin
                    cmd.op     = rmh_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            S_POPV:
            begin
                cmd.op     = rmh_pkg::OP_POP_LOADV;
                state_next = S_SINK;
            end
            S_SINK:
            begin
                if (status.left_lt_n)
                begin
                    cmd.op     = rmh_pkg::OP_READ_LEFT;
                    state_next = S_LEFT;
                end
                else
                begin
                    cmd.op     = rmh_pkg::OP_PLACE;
                    state_next = S_XFER;
                end
            end
            S_LEFT:
            begin
                cmd.op     = rmh_pkg::OP_TAKE_LEFT;
                state_next = status.right_lt_n ? S_RIGHT : S_DEC;
            end
            S_RIGHT:
            begin
                cmd.op     = rmh_pkg::OP_TAKE_RIGHT;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (status.best_is_idx)
                begin
                    cmd.op     = rmh_pkg::OP_PLACE;
                    state_next = S_XFER;
                end
                else
                begin
                    cmd.op     = rmh_pkg::OP_SINK_STEP;
                    state_next = S_SINK;
                end
            end
            S_XFER:
            begin
                sel_next       = !sel_reg;
                cmd.sel        = !sel_reg;
                cmd.src_popped = 1'b1;
                cmd.op         = rmh_pkg::OP_PUSH_BEGIN;
                state_next     = S_PUSH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            done_reg  <= (cmd.op == rmh_pkg::OP_FINISH);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ----- rtl/rmh_datapath.sv -----
// Heap memories, counts, top-of-heap shadows and the result registers.
// Depends on rmh_pkg; driven by rmh_ctrl commands.
module rmh_datapath #(
    parameter int CAPACITY = rmh_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [rmh_pkg::DATA_W-1:0] sample,
    input  rmh_pkg::cmd_t                     cmd,
    output rmh_pkg::status_t                  status,
    output logic signed [rmh_pkg::MED_W-1:0]  median_times_two,
    output logic [$clog2(CAPACITY+1)-1:0]     sample_count,
    output logic                              overflow
);

    localparam int DEPTH = CAPACITY / 2 + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(CAPACITY + 1);
    localparam int DW    = rmh_pkg::DATA_W;

    logic signed [DW-1:0] lmem [DEPTH];
    logic signed [DW-1:0] umem [DEPTH];

    logic [CW-1:0]        lcnt_reg, ucnt_reg, idx_reg, n_reg, besti_reg;
    logic signed [DW-1:0] ltop_reg, utop_reg, sample_reg, val_reg, popped_reg;
    logic signed [DW-1:0] bestv_reg, rdata_reg;
    logic signed [rmh_pkg::MED_W-1:0] median_reg;
    logic [NW-1:0]        count_reg;
    logic                 ovf_reg;

    logic [CW-1:0]        cnt_sel, parent;
    logic [CW:0]          lft, rgt, total;
    logic signed [DW-1:0] top_sel, wdata;
    logic [CW-1:0]        raddr, waddr;
    logic                 re, we;
    logic signed [rmh_pkg::MED_W-1:0] med_calc;

    assign cnt_sel = cmd.sel ? ucnt_reg : lcnt_reg;
    assign top_sel = cmd.sel ? utop_reg : ltop_reg;
    assign parent  = (idx_reg - CW'(1)) >> 1;
    assign lft     = {idx_reg, 1'b1};
    assign rgt     = lft + (CW+1)'(1);
    assign total   = {1'b0, lcnt_reg} + {1'b0, ucnt_reg};

    always_comb
    begin
        re    = 1'b0;
        raddr = '0;
        we    = 1'b0;
        waddr = idx_reg;
        wdata = val_reg;
        case (cmd.op)
            rmh_pkg::OP_READ_PARENT: begin re = 1'b1; raddr = parent; end
            rmh_pkg::OP_POP_BEGIN:   begin re = 1'b1; raddr = cnt_sel - CW'(1); end
            rmh_pkg::OP_READ_LEFT:   begin re = 1'b1; raddr = lft[CW-1:0]; end
            rmh_pkg::OP_TAKE_LEFT:   begin re = 1'b1; raddr = rgt[CW-1:0]; end
            rmh_pkg::OP_PUSH_MOVE:   begin we = 1'b1; wdata = rdata_reg; end
            rmh_pkg::OP_PLACE:       begin we = 1'b1; wdata = val_reg; end
            rmh_pkg::OP_SINK_STEP:   begin we = 1'b1; wdata = bestv_reg; end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    // memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we && !cmd.sel)
            lmem[waddr[AW-1:0]] <= wdata;
        if (we && cmd.sel)
            umem[waddr[AW-1:0]] <= wdata;
        if (re)
            rdata_reg <= cmd.sel ? umem[raddr[AW-1:0]] : lmem[raddr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcnt_reg <= '0;
            ucnt_reg <= '0;
        end
        else if (cmd.op == rmh_pkg::OP_PUSH_BEGIN)
        begin
            if (cmd.sel)
                ucnt_reg <= ucnt_reg + CW'(1);
            else
                lcnt_reg <= lcnt_reg + CW'(1);
        end
        else if (cmd.op == rmh_pkg::OP_POP_BEGIN)
        begin
            if (cmd.sel)
                ucnt_reg <= ucnt_reg - CW'(1);
            else
                lcnt_reg <= lcnt_reg - CW'(1);
        end
    end

    always_comb
    begin
        if (lcnt_reg == '0)
            med_calc = '0;
        else if (lcnt_reg == ucnt_reg)
            med_calc = {ltop_reg[DW-1], ltop_reg} + {utop_reg[DW-1], utop_reg};
        else
            med_calc = {ltop_reg, 1'b0};
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (we && waddr == '0)
        begin
            if (cmd.sel)
                utop_reg <= wdata;
            else
                ltop_reg <= wdata;
        end
        case (cmd.op)
            rmh_pkg::OP_LOAD:
                sample_reg <= sample;
            rmh_pkg::OP_PUSH_BEGIN:
            begin
                val_reg <= cmd.src_popped ? popped_reg : sample_reg;
                idx_reg <= cnt_sel;
            end
            rmh_pkg::OP_PUSH_MOVE:
                idx_reg <= parent;
            rmh_pkg::OP_POP_BEGIN:
            begin
                popped_reg <= top_sel;
                n_reg      <= cnt_sel - CW'(1);
                idx_reg    <= '0;
            end
            rmh_pkg::OP_POP_LOADV:
                val_reg <= rdata_reg;
            rmh_pkg::OP_TAKE_LEFT:
            begin
                if (rmh_pkg::above(rdata_reg, val_reg, cmd.sel))
                begin
                    bestv_reg <= rdata_reg;
                    besti_reg <= lft[CW-1:0];
                end
                else
                begin
                    bestv_reg <= val_reg;
                    besti_reg <= idx_reg;
                end
            end
            rmh_pkg::OP_TAKE_RIGHT:
            begin
                if (rmh_pkg::above(rdata_reg, bestv_reg, cmd.sel))
                begin
                    bestv_reg <= rdata_reg;
                    besti_reg <= rgt[CW-1:0];
                end
            end
            rmh_pkg::OP_SINK_STEP:
                idx_reg <= besti_reg;
            rmh_pkg::OP_FINISH:
            begin
                median_reg <= med_calc;
                count_reg  <= NW'(total);
                ovf_reg    <= cmd.ovf;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign status.idx_zero     = (idx_reg == '0);
    assign status.above_parent = rmh_pkg::above(val_reg, rdata_reg, cmd.sel);
    assign status.left_lt_n    = (lft < {1'b0, n_reg});
    assign status.right_lt_n   = (rgt < {1'b0, n_reg});
    assign status.best_is_idx  = (besti_reg == idx_reg);
    assign status.full         = (32'(total) >= 32'(CAPACITY));
    assign status.go_lower     = (lcnt_reg == '0) || (sample_reg <= ltop_reg);
    assign status.need_l2u     = ({1'b0, lcnt_reg} == {1'b0, ucnt_reg} + (CW+1)'(2));
    assign status.need_u2l     = ({1'b0, lcnt_reg} + (CW+1)'(1) == {1'b0, ucnt_reg});

    assign median_times_two = median_reg;
    assign sample_count     = count_reg;
    assign overflow         = ovf_reg;

endmodule
